// ===== rtl/ptrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_pkg: shared definitions for the periodic task release scheduler
// Slot count, field widths, register indexes, item codes, microcode format
// and the microcode program itself.
// ----------------------------------------------------------------------------
package ptrs_pkg;

   localparam int SLOTS  = 4;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TIME_W = 32;

   // Fixed field widths of the ports.
   localparam int MODE_W    = 2;
   localparam int REQ_SLOT_W = 3;
   localparam int FIRED_W   = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_MASK = 3'd4;

   localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd1000;

   // Item codes.
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENABLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_START  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STOP   = 2'd3;

   // Micro-operations driven by one control word.
   typedef enum logic [2:0] {
      UOP_FETCH,
      UOP_SCAN,
      UOP_EMIT,
      UOP_ENABLE,
      UOP_RESTAMP,
      UOP_RUN,
      UOP_HALT,
      UOP_NOP
   } uop_type;

   // Sequencing: where the step counter goes after a step.
   typedef enum logic [1:0] {
      JMP_DISPATCH,
      JMP_ALWAYS,
      JMP_CURSOR_MORE,
      JMP_MASK_MORE
   } jmp_type;

   localparam int UPC_W = 3;
   typedef logic [UPC_W-1:0] upc_type;

   // Program addresses. The emit step sits at the top address so that its
   // fall-through wraps back to the fetch step.
   localparam upc_type UPC_FETCH   = 3'd0;
   localparam upc_type UPC_ENABLE  = 3'd1;
   localparam upc_type UPC_RESTAMP = 3'd2;
   localparam upc_type UPC_RUN     = 3'd3;
   localparam upc_type UPC_HALT    = 3'd4;
   localparam upc_type UPC_SPARE   = 3'd5;
   localparam upc_type UPC_SCAN    = 3'd6;
   localparam upc_type UPC_EMIT    = 3'd7;

   typedef struct packed {
      uop_type uop;
      jmp_type jmp;
      upc_type target;
   } uword_type;

   // Commands from the sequencer to the slot bank.
   typedef struct packed {
      logic              scan;
      logic              restamp;
      logic              set_en;
      logic              en_value;
      logic [SLOT_W-1:0] idx;
   } bank_cmd_type;

   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type w;
      unique case (pc)
         UPC_FETCH:   w = '{uop: UOP_FETCH,   jmp: JMP_DISPATCH,    target: UPC_FETCH};
         UPC_ENABLE:  w = '{uop: UOP_ENABLE,  jmp: JMP_ALWAYS,      target: UPC_EMIT};
         UPC_RESTAMP: w = '{uop: UOP_RESTAMP, jmp: JMP_CURSOR_MORE, target: UPC_RESTAMP};
         UPC_RUN:     w = '{uop: UOP_RUN,     jmp: JMP_ALWAYS,      target: UPC_EMIT};
         UPC_HALT:    w = '{uop: UOP_HALT,    jmp: JMP_ALWAYS,      target: UPC_EMIT};
         UPC_SPARE:   w = '{uop: UOP_NOP,     jmp: JMP_ALWAYS,      target: UPC_FETCH};
         UPC_SCAN:    w = '{uop: UOP_SCAN,    jmp: JMP_CURSOR_MORE, target: UPC_SCAN};
         UPC_EMIT:    w = '{uop: UOP_EMIT,    jmp: JMP_MASK_MORE,   target: UPC_EMIT};
         default:     w = '{uop: UOP_NOP,     jmp: JMP_ALWAYS,      target: UPC_FETCH};
      endcase
      return w;
   endfunction

   // Entry point of the program for a newly accepted item.
   function automatic upc_type dispatch(input logic [MODE_W-1:0] mode, input logic running);
      upc_type t;
      unique case (mode)
         MODE_TICK:   t = running ? UPC_SCAN : UPC_EMIT;
         MODE_ENABLE: t = UPC_ENABLE;
         MODE_START:  t = UPC_RESTAMP;
         MODE_STOP:   t = UPC_HALT;
         default:     t = UPC_EMIT;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ptrs_slot_bank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_slot_bank: per-slot state and the shared due compare
// Holds the interval and present registers, the enable bits and the
// last-release stamps, and evaluates one slot per cycle.
// ----------------------------------------------------------------------------
module ptrs_slot_bank (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wen,
   input  wire logic [ptrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ptrs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire ptrs_pkg::bank_cmd_type          cmd,
   input  wire logic [ptrs_pkg::TIME_W-1:0]    now_ms,
   output logic                                due
);
   import ptrs_pkg::*;

   logic [TIME_W-1:0] interval_ff [SLOTS];
   logic [TIME_W-1:0] interval_in [SLOTS];
   logic [TIME_W-1:0] stamp_ff    [SLOTS];
   logic [TIME_W-1:0] stamp_in    [SLOTS];
   logic [SLOTS-1:0]  present_ff, present_in;
   logic [SLOTS-1:0]  enabled_ff, enabled_in;
   logic [TIME_W-1:0] elapsed;

   // Wrap-around elapsed time for the addressed slot, one shared compare.
   assign elapsed = now_ms - stamp_ff[cmd.idx];
   assign due     = enabled_ff[cmd.idx] && present_ff[cmd.idx] &&
                    (elapsed >= interval_ff[cmd.idx]);

   always_comb begin
      interval_in = interval_ff;
      stamp_in    = stamp_ff;
      present_in  = present_ff;
      enabled_in  = enabled_ff;
      for (int i = 0; i < SLOTS; i++) begin
         if (csr_wen && (csr_index == CSR_IDX_W'(i))) begin
            interval_in[i] = csr_wdata[TIME_W-1:0];
         end
      end
      if (csr_wen && (csr_index == CSR_PRESENT_MASK)) begin
         present_in = csr_wdata[SLOTS-1:0];
      end
      if (cmd.scan && due) begin
         stamp_in[cmd.idx] = now_ms;
      end
      if (cmd.restamp && enabled_ff[cmd.idx]) begin
         stamp_in[cmd.idx] = now_ms;
      end
      if (cmd.set_en) begin
         enabled_in[cmd.idx] = cmd.en_value;
         if (cmd.en_value) begin
            stamp_in[cmd.idx] = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            interval_ff[i] <= INTERVAL_RESET;
            stamp_ff[i]    <= '0;
         end
         present_ff <= '0;
         enabled_ff <= '0;
      end else begin
         interval_ff <= interval_in;
         stamp_ff    <= stamp_in;
         present_ff  <= present_in;
         enabled_ff  <= enabled_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/periodic_task_release_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler: microcoded periodic task release scheduler
// Releases due task slots on each millisecond tick while running, in ascending slot order.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and answers it with one or more
// response beats; the final beat of a request carries rsp_last. A request is
// taken in the fetch step. A tick while running then scans the four slots one
// per cycle through a single shared subtract-and-compare and emits one beat
// per released slot (one beat if none). A tick while stopped goes straight to
// the emit step. An enable or stop request runs its own step and then the emit
// step; a start request first restamps the enabled slots one per cycle and
// then sets the running flag. The emit step holds while a finished beat is
// stalled. The response register lets the next request's work proceed while
// a finished beat still waits to be taken. Configuration writes (interval per
// slot at indexes zero to three, present mask at index four) are taken in any
// cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ptrs_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [ptrs_pkg::TIME_W-1:0]      req_now_ms,
   input  wire logic [ptrs_pkg::REQ_SLOT_W-1:0]  req_slot,
   input  wire logic                             req_enable_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_fire,
   output logic [ptrs_pkg::FIRED_W-1:0]          rsp_fired_slot,
   output logic                                  rsp_bad_slot,
   output logic                                  rsp_last,
   input  wire logic                             csr_wen,
   input  wire logic [ptrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ptrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ptrs_pkg::*;

   // Sequencer state.
   upc_type             upc_ff, upc_in;
   logic [SLOT_W-1:0]   cursor_ff, cursor_in;
   logic [SLOTS-1:0]    mask_ff, mask_in;
   logic                running_ff, running_in;
   logic                bad_ff, bad_in;

   // Latched request beat.
   logic                en_ff, en_in;
   logic [REQ_SLOT_W-1:0] slot_ff, slot_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fire_ff, rsp_fire_in;
   logic [FIRED_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                rsp_bad_ff, rsp_bad_in;
   logic                rsp_last_ff, rsp_last_in;

   uword_type           uword;
   logic                accept;
   logic                out_busy;
   logic                hold;
   logic                emit;
   logic                taken;
   upc_type             jump_target;
   logic [SLOT_W-1:0]   first_idx;
   logic [SLOTS-1:0]    first_oh;
   logic [SLOTS-1:0]    mask_rest;
   logic                due;
   bank_cmd_type        bank_cmd;

   assign uword     = ucode_rom(upc_ff);
   assign req_stall = (uword.uop != UOP_FETCH);
   assign accept    = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit      = (uword.uop == UOP_EMIT) && !out_busy;
   assign hold      = ((uword.uop == UOP_FETCH) && !req_valid) ||
                      ((uword.uop == UOP_EMIT) && out_busy);

   // Lowest pending released slot; the emit step walks the mask upward.
   always_comb begin
      first_idx = '0;
      first_oh  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            first_idx   = SLOT_W'(i);
            first_oh    = '0;
            first_oh[i] = 1'b1;
         end
      end
   end
   assign mask_rest = mask_ff & ~first_oh;

   // Step counter: hold, take the conditional jump, or fall through.
   always_comb begin
      taken       = 1'b0;
      jump_target = uword.target;
      unique case (uword.jmp)
         JMP_DISPATCH: begin
            taken       = 1'b1;
            jump_target = dispatch(req_mode, running_ff);
         end
         JMP_ALWAYS:      taken = 1'b1;
         JMP_CURSOR_MORE: taken = (cursor_ff != SLOT_W'(SLOTS - 1));
         JMP_MASK_MORE:   taken = |mask_rest;
         default:         taken = 1'b1;
      endcase
      if (hold) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = jump_target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   // Datapath driven by the current control word.
   always_comb begin
      cursor_in  = cursor_ff;
      mask_in    = mask_ff;
      running_in = running_ff;
      bad_in     = bad_ff;
      en_in      = en_ff;
      slot_in    = slot_ff;
      now_in     = now_ff;
      unique case (uword.uop)
         UOP_FETCH: begin
            cursor_in = '0;
            mask_in   = '0;
            if (accept) begin
               en_in   = req_enable_value;
               slot_in = req_slot;
               now_in  = req_now_ms;
               bad_in  = (req_mode == MODE_ENABLE) && (int'(req_slot) >= SLOTS);
            end
         end
         UOP_SCAN: begin
            mask_in[cursor_ff] = due;
            cursor_in          = cursor_ff + SLOT_W'(1);
         end
         UOP_RESTAMP: cursor_in = cursor_ff + SLOT_W'(1);
         UOP_RUN:     running_in = 1'b1;
         UOP_HALT:    running_in = 1'b0;
         UOP_EMIT: begin
            if (!out_busy) begin
               mask_in = mask_rest;
            end
         end
         UOP_ENABLE, UOP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      bank_cmd.scan     = (uword.uop == UOP_SCAN);
      bank_cmd.restamp  = (uword.uop == UOP_RESTAMP);
      bank_cmd.set_en   = (uword.uop == UOP_ENABLE) && !bad_ff;
      bank_cmd.en_value = en_ff;
      bank_cmd.idx      = (uword.uop == UOP_ENABLE) ? slot_ff[SLOT_W-1:0] : cursor_ff;
   end

   ptrs_slot_bank u_bank (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (bank_cmd),
      .now_ms    (now_ff),
      .due       (due)
   );

   // Response register: loaded by the emit step, drained when not stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_fire_in  = rsp_fire_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_fire_in  = |mask_ff;
         rsp_slot_in  = FIRED_W'(first_idx);
         rsp_bad_in   = bad_ff;
         rsp_last_in  = ~|mask_rest;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_FETCH;
         cursor_ff    <= '0;
         mask_ff      <= '0;
         running_ff   <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         cursor_ff    <= cursor_in;
         mask_ff      <= mask_in;
         running_ff   <= running_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      en_ff       <= en_in;
      slot_ff     <= slot_in;
      now_ff      <= now_in;
      rsp_fire_ff <= rsp_fire_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fire       = rsp_fire_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_bad_slot   = rsp_bad_ff;
   assign rsp_last       = rsp_last_ff;

   // A taken request always leaves the fetch step.
   a_leave_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> (upc_ff != UPC_FETCH))
      else $error("sequencer stayed in fetch after taking a request");

   // Every request starts with an empty release mask.
   a_mask_cleared: assert property (@(posedge clock) disable iff (reset)
      accept |=> (mask_ff == '0))
      else $error("release mask not cleared on a new request");

   // An error beat never releases a slot and is the only beat of its request.
   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (!rsp_fire_ff && rsp_last_ff))
      else $error("error beat carries a release or is not final");

   // The running flag only changes in the start and stop steps.
   a_running_steps: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (running_ff != $past(running_ff))) |->
      ($past(upc_ff) == UPC_RUN || $past(upc_ff) == UPC_HALT))
      else $error("running flag changed outside start or stop");

endmodule
`default_nettype wire

// ===== sim/ptrs_release_check.sv =====
// ----------------------------------------------------------------------------
// ptrs_release_check: response checker for the periodic task release scheduler
// Watches the request, response and register ports, keeps its own copy of the
// slot bank, and compares every response beat with the beats it owes.
// ----------------------------------------------------------------------------
module ptrs_release_check
   import ptrs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic [MODE_W-1:0]       req_mode,
   input  wire logic [TIME_W-1:0]       req_now_ms,
   input  wire logic [REQ_SLOT_W-1:0]   req_slot,
   input  wire logic                    req_enable_value,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic                    rsp_fire,
   input  wire logic [FIRED_W-1:0]      rsp_fired_slot,
   input  wire logic                    rsp_bad_slot,
   input  wire logic                    rsp_last,
   input  wire logic                    csr_wen,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned                  mismatch_count,
   output int unsigned                  beats_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               fire;
      logic [FIRED_W-1:0] fired_slot;
      logic               bad_slot;
      logic               last;
   } rsp_beat_t;

   // Shadow copy of the slot bank and its registers.
   logic                running_q;
   logic [SLOTS-1:0]    enabled_q;
   logic [TIME_W-1:0]   stamp_q [SLOTS];
   logic [TIME_W-1:0]   period_q [SLOTS];
   logic [SLOTS-1:0]    present_q;

   rsp_beat_t owed_beats [$];

   // Works out the beats one request causes and updates the shadow bank.
   task automatic predict_releases(input logic [MODE_W-1:0] mode,
                                   input logic [TIME_W-1:0] now,
                                   input logic [REQ_SLOT_W-1:0] slot,
                                   input logic en);
      rsp_beat_t beats [SLOTS];
      int n;
      int i;
      n = 0;
      case (mode)
         MODE_TICK: begin
            if (running_q) begin
               for (i = 0; i < SLOTS; i++) begin
                  // Elapsed time is taken modulo 2^32 so a wrapped clock still works.
                  if (enabled_q[i] && present_q[i] && (now - stamp_q[i]) >= period_q[i]) begin
                     stamp_q[i] = now;
                     beats[n] = '{fire: 1'b1, fired_slot: FIRED_W'(i), bad_slot: 1'b0,
                                  last: 1'b0};
                     n++;
                  end
               end
            end
         end
         MODE_ENABLE: begin
            if (slot >= SLOTS) begin
               beats[0] = '{fire: 1'b0, fired_slot: '0, bad_slot: 1'b1, last: 1'b0};
               n = 1;
            end else begin
               enabled_q[slot[SLOT_W-1:0]] = en;
               if (en) begin
                  stamp_q[slot[SLOT_W-1:0]] = now;
               end
            end
         end
         MODE_START: begin
            running_q = 1'b1;
            for (i = 0; i < SLOTS; i++) begin
               if (enabled_q[i]) begin
                  stamp_q[i] = now;
               end
            end
         end
         MODE_STOP: begin
            running_q = 1'b0;
         end
      endcase
      if (n == 0) begin
         beats[0] = '{fire: 1'b0, fired_slot: '0, bad_slot: 1'b0, last: 1'b0};
         n = 1;
      end
      beats[n-1].last = 1'b1;
      for (i = 0; i < n; i++) begin
         owed_beats.push_back(beats[i]);
      end
   endtask

   function automatic bit field_differs(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      rsp_beat_t want;
      int i;
      if (reset) begin
         running_q = 1'b0;
         enabled_q = '0;
         present_q = '0;
         for (i = 0; i < SLOTS; i++) begin
            stamp_q[i] = '0;
            period_q[i] = INTERVAL_RESET;
         end
         owed_beats.delete();
         mismatch_count = 0;
      end else begin
         // Responses first: a beat taken at this edge can never belong to a
         // request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (owed_beats.size() == 0) begin
               $display("%0t: response beat with nothing owed, expected none, got fire %0d slot %0d bad %0d last %0d",
                        $time, rsp_fire, rsp_fired_slot, rsp_bad_slot, rsp_last);
               mismatch_count++;
            end else begin
               want = owed_beats.pop_front();
               if (field_differs("fire", 2'(want.fire), 2'(rsp_fire)) |
                   field_differs("fired_slot", 2'(want.fired_slot), 2'(rsp_fired_slot)) |
                   field_differs("bad_slot", 2'(want.bad_slot), 2'(rsp_bad_slot)) |
                   field_differs("last", 2'(want.last), 2'(rsp_last))) begin
                  mismatch_count++;
               end
            end
         end
         if (csr_wen) begin
            if (csr_index < SLOTS) begin
               period_q[csr_index[SLOT_W-1:0]] = csr_wdata[TIME_W-1:0];
            end else if (csr_index == CSR_PRESENT_MASK) begin
               present_q = csr_wdata[SLOTS-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            predict_releases(req_mode, req_now_ms, req_slot, req_enable_value);
         end
      end
      beats_awaited = owed_beats.size();
   end

endmodule

// ===== sim/periodic_task_release_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_test: top level for the release scheduler
// Drives directed and random request beats through the block under random
// idling on both sides and leaves all checking to ptrs_release_check.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ptrs_pkg::*;

   // The run is cut off here; a correct run needs a small fraction of it.
   localparam int LIMIT_CYCLES = 300000;
   // Length of the one long response hold-off.
   localparam int HOLD_CYCLES  = 400;
   // Quiet cycles after the last owed beat, so the block can finish its last request.
   localparam int SETTLE_CYCLES = 12;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MODE_W-1:0]       req_mode = MODE_TICK;
   logic [TIME_W-1:0]       req_now_ms = '0;
   logic [REQ_SLOT_W-1:0]   req_slot = '0;
   logic                    req_enable_value = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_fire;
   logic [FIRED_W-1:0]      rsp_fired_slot;
   logic                    rsp_bad_slot;
   logic                    rsp_last;
   logic                    csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned beats_awaited;

   // Idle rates in percent for each side, and the trigger for the hold-off.
   int unsigned send_gap_pct = 35;
   int unsigned rsp_gap_pct = 35;
   logic        hold_go = 1'b0;

   // Millisecond clock that the random ticks walk forward.
   logic [TIME_W-1:0] wall_ms;
   int                cycle_count;

   periodic_task_release_scheduler dut (.*);

   ptrs_release_check release_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one request beat and returns at the edge that takes it. The
   // payload stays put while the block stalls, and valid is only lowered
   // for an idle cycle, never within the step that raises it.
   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now,
                           input logic [REQ_SLOT_W-1:0] slot, input logic en);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_now_ms <= now;
      req_slot <= slot;
      req_enable_value <= en;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Stops offering and waits until every owed beat has come back, then lets
   // the block finish its last request. The count is read on the falling edge
   // so it never races the checker's update.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (beats_awaited != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all five registers, one per cycle, while the block is idle.
   task automatic set_regs(input logic [TIME_W-1:0] p0, input logic [TIME_W-1:0] p1,
                           input logic [TIME_W-1:0] p2, input logic [TIME_W-1:0] p3,
                           input logic [SLOTS-1:0] mask);
      logic [TIME_W-1:0] periods [SLOTS];
      int i;
      periods = '{p0, p1, p2, p3};
      for (i = 0; i < SLOTS; i++) begin
         csr_wen <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= periods[i];
         @(posedge clock);
      end
      csr_index <= CSR_PRESENT_MASK;
      csr_wdata <= CSR_DATA_W'(mask);
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Periods lean to small values so that slots come due often, with the
   // extremes and a fully random value mixed in.
   function automatic logic [TIME_W-1:0] pick_period();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3: return 1;
         default: return TIME_W'($urandom_range(12));
      endcase
   endfunction

   // One phase of random traffic. It opens with a well-formed sequence that
   // enables the slots and starts the scheduler, then mostly ticks with time
   // moving forward by small steps, mixed with enables (some of them naming
   // slots that do not exist), restarts, stops and fully random beats.
   task automatic run_phase(input int count);
      int k;
      int roll;
      logic [REQ_SLOT_W-1:0] pick;
      for (k = 0; k < SLOTS; k++) begin
         send_req(MODE_ENABLE, wall_ms, REQ_SLOT_W'(k), $urandom_range(3) != 0);
      end
      send_req(MODE_START, wall_ms, REQ_SLOT_W'($urandom), 1'($urandom));
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 62) begin
            // Now and then time jumps far, which also lands behind a stamp.
            wall_ms = wall_ms + (($urandom_range(19) == 0) ? $urandom : $urandom_range(3));
            send_req(MODE_TICK, wall_ms, REQ_SLOT_W'($urandom), 1'($urandom));
         end else if (roll < 77) begin
            pick = ($urandom_range(7) == 0) ? REQ_SLOT_W'($urandom_range(7, SLOTS))
                                            : REQ_SLOT_W'($urandom_range(SLOTS-1));
            send_req(MODE_ENABLE, wall_ms, pick, 1'($urandom));
         end else if (roll < 84) begin
            send_req(MODE_START, wall_ms, REQ_SLOT_W'($urandom), 1'($urandom));
         end else if (roll < 89) begin
            send_req(MODE_STOP, wall_ms, REQ_SLOT_W'($urandom), 1'($urandom));
         end else begin
            send_req(MODE_W'($urandom), $urandom, REQ_SLOT_W'($urandom), 1'($urandom));
         end
      end
   endtask

   // Response side. It stalls at random, except for one long hold-off that
   // it counts itself once the stimulus asks for it.
   initial begin : response_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Slot zero has period zero, slot one period one, slot
      // two the largest period and slot three period five, all present.
      set_regs('0, 1, '1, 5, '1);
      send_req(MODE_TICK, 32'd0, 3'd0, 1'b0);            // tick while stopped
      send_req(MODE_ENABLE, 32'd50, 3'd7, 1'b1);         // slot out of range
      send_req(MODE_ENABLE, 32'd50, 3'd4, 1'b0);         // first slot out of range
      send_req(MODE_ENABLE, 32'd100, 3'd0, 1'b1);
      send_req(MODE_ENABLE, 32'd100, 3'd1, 1'b1);
      send_req(MODE_ENABLE, 32'd100, 3'd2, 1'b1);
      send_req(MODE_ENABLE, 32'd100, 3'd3, 1'b1);
      send_req(MODE_TICK, 32'd200, 3'd0, 1'b0);          // still stopped
      send_req(MODE_START, 32'd1000, 3'd0, 1'b0);        // restamps all four
      send_req(MODE_TICK, 32'd1000, 3'd0, 1'b0);         // only the zero period
      send_req(MODE_TICK, 32'd1001, 3'd0, 1'b0);         // slots zero and one
      // Going back one millisecond wraps each elapsed time to the maximum or
      // one below, so every slot is due, the largest period too: four beats.
      send_req(MODE_TICK, 32'd999, 3'd0, 1'b0);
      send_req(MODE_START, 32'hFFFF_FFFE, 3'd0, 1'b0);   // start while running
      send_req(MODE_TICK, 32'd3, 3'd0, 1'b0);            // elapsed across the wrap
      send_req(MODE_ENABLE, 32'hFFFF_FFFF, 3'd1, 1'b0);  // disable keeps the stamp
      send_req(MODE_TICK, 32'd10, 3'd0, 1'b0);
      send_req(MODE_STOP, 32'd10, 3'd0, 1'b0);
      send_req(MODE_TICK, 32'd500, 3'd0, 1'b0);          // stopped, nothing due
      send_req(MODE_ENABLE, 32'hFFFF_FFFF, 3'd1, 1'b1);  // enable while stopped
      send_req(MODE_STOP, 32'd20, 3'd0, 1'b0);           // stop while stopped
      send_req(MODE_START, 32'd20, 3'd0, 1'b0);
      send_req(MODE_TICK, 32'd20, 3'd0, 1'b0);
      // The sender waits here until every owed beat has come back.
      settle();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_regs('0, '0, '0, '0, '1);   // each running tick releases every enabled slot
            1: set_regs('1, '1, '1, '1, '0);   // no handlers installed
            default: set_regs(pick_period(), pick_period(), pick_period(), pick_period(),
                              SLOTS'($urandom));
         endcase
         // Phase five runs without idling on either side; phase three keeps
         // the sender busy while the response side holds off for a long time,
         // so the block fills up and stalls its input.
         send_gap_pct = (phase == 3 || phase == 5) ? 0 : 35;
         rsp_gap_pct <= (phase == 5) ? 0 : 35;
         if (phase == 3) begin
            hold_go <= 1'b1;
         end
         wall_ms = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - $urandom_range(40) : $urandom;
         run_phase(52);
         settle();
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
